[hdl/evt_pkg.sv]
`timescale 1ns / 1ps

package evt_pkg;

    localparam int NUM_SATS        = 32;
    localparam int ENTRIES_PER_SAT = 16;
    localparam int TIME_BITS       = 40;

    localparam int SAT_BITS      = 5;
    localparam int TAG_BITS      = 32;
    localparam int STATUS_BITS   = 4;
    localparam int SAT_IDX_BITS  = (NUM_SATS > 1) ? $clog2(NUM_SATS) : 1;
    localparam int SLOT_BITS     = $clog2(ENTRIES_PER_SAT);
    localparam int FILL_BITS     = $clog2(ENTRIES_PER_SAT + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_ADDED     = 4'd0;
    localparam logic [STATUS_BITS-1:0] ST_REPLACED  = 4'd1;
    localparam logic [STATUS_BITS-1:0] ST_DUPLICATE = 4'd2;
    localparam logic [STATUS_BITS-1:0] ST_CONFLICT  = 4'd3;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 4'd4;
    localparam logic [STATUS_BITS-1:0] ST_FOUND     = 4'd5;
    localparam logic [STATUS_BITS-1:0] ST_NONE      = 4'd6;
    localparam logic [STATUS_BITS-1:0] ST_TOO_EARLY = 4'd7;
    localparam logic [STATUS_BITS-1:0] ST_TOO_LATE  = 4'd8;
    localparam logic [STATUS_BITS-1:0] ST_GAP       = 4'd9;

    typedef struct packed {
        logic [TIME_BITS-1:0] key;
        logic [TIME_BITS-1:0] stop;
        logic [TIME_BITS-1:0] epoch;
        logic [TAG_BITS-1:0]  tag;
        logic                 healthy;
    } entry_t;

    typedef struct packed {
        logic                   load;
        logic                   scan_adv;
        logic                   rd_prev;
        logic                   add_start;
        logic                   p_from_n;
        logic                   shift_wr;
        logic                   wr_new;
        logic                   fill_inc;
        logic                   res_set;
        logic [STATUS_BITS-1:0] res_status;
        logic                   res_found;
        logic                   res_from_cur;
        logic                   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic sat_ok;
        logic is_lookup;
        logic n_zero;
        logic n_full;
        logic last;
        logic idx_zero;
        logic idx_at_p;
        logic key_ge;
        logic key_eq;
        logic cur_ep_eq;
        logic prev_ep_eq;
        logic cur_in_range;
        logic prev_in_range;
    } dp_stat_t;

endpackage

[hdl/evt_in_if.sv]
`timescale 1ns / 1ps

interface evt_in_if import evt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [SAT_BITS-1:0]  sat_id;
    logic [TIME_BITS-1:0] begin_valid;
    logic [TIME_BITS-1:0] end_valid;
    logic [TIME_BITS-1:0] toe_time;
    logic [TAG_BITS-1:0]  entry_tag;
    logic                 entry_healthy;
    logic [TIME_BITS-1:0] query_time;

    modport source (output valid, opcode, sat_id, begin_valid, end_valid, toe_time,
                    entry_tag, entry_healthy, query_time, input ready);
    modport sink (input valid, opcode, sat_id, begin_valid, end_valid, toe_time,
                  entry_tag, entry_healthy, query_time, output ready);
endinterface

[hdl/evt_out_if.sv]
`timescale 1ns / 1ps

interface evt_out_if import evt_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [TAG_BITS-1:0]    found_tag;
    logic [TIME_BITS-1:0]   found_begin;
    logic [TIME_BITS-1:0]   found_end;
    logic [TIME_BITS-1:0]   found_toe;
    logic                   found_healthy;

    modport source (output valid, status, found_tag, found_begin, found_end, found_toe,
                    found_healthy, input ready);
    modport sink (input valid, status, found_tag, found_begin, found_end, found_toe,
                  found_healthy, output ready);
endinterface

[hdl/evt_dp.sv]
`timescale 1ns / 1ps

module evt_dp import evt_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    evt_in_if.sink        in_ch,
    output logic [STATUS_BITS-1:0] out_status,
    output entry_t        out_entry,
    input  dp_cmd_t       cmd,
    output dp_stat_t      stat
);

    entry_t mem [NUM_SATS][ENTRIES_PER_SAT];
    logic [FILL_BITS-1:0] fill_reg [NUM_SATS];

    logic                    op_reg;
    logic [SAT_IDX_BITS-1:0] sat_reg;
    logic                    sat_ok_reg;
    entry_t                  new_reg;
    logic [TIME_BITS-1:0]    query_reg;
    logic [FILL_BITS-1:0]    n_reg;
    logic [FILL_BITS-1:0]    idx_reg;
    logic [FILL_BITS-1:0]    idx_next;
    logic [FILL_BITS-1:0]    p_reg;
    entry_t                  prev_reg;
    entry_t                  rdata_reg;
    logic [STATUS_BITS-1:0]  res_status_reg;
    entry_t                  res_entry_reg;
    logic [STATUS_BITS-1:0]  out_status_reg;
    entry_t                  out_entry_reg;

    logic                    in_sat_ok;
    logic [SAT_IDX_BITS-1:0] in_sat;
    logic [FILL_BITS-1:0]    rd_idx;
    logic [SLOT_BITS-1:0]    rd_slot;
    logic [SLOT_BITS-1:0]    wr_slot;
    logic [TIME_BITS-1:0]    cmp_val;

    assign in_sat_ok = 7'(in_ch.sat_id) < 7'(NUM_SATS);
    assign in_sat    = SAT_IDX_BITS'(in_ch.sat_id);
    assign rd_idx    = cmd.rd_prev ? (idx_reg - 1'b1) : idx_reg;
    assign rd_slot   = rd_idx[SLOT_BITS-1:0];
    assign wr_slot   = idx_reg[SLOT_BITS-1:0];
    assign cmp_val   = (op_reg == OP_LOOKUP) ? query_reg : new_reg.key;

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.scan_adv)
        begin
            idx_next = idx_reg + 1'b1;
        end
        else if (cmd.add_start)
        begin
            idx_next = n_reg;
        end
        else if (cmd.shift_wr)
        begin
            idx_next = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[sat_reg][rd_slot];
        if (cmd.shift_wr)
        begin
            mem[sat_reg][wr_slot] <= rdata_reg;
        end
        else if (cmd.wr_new)
        begin
            mem[sat_reg][wr_slot] <= new_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SATS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else if (cmd.fill_inc)
        begin
            fill_reg[sat_reg] <= n_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load)
        begin
            op_reg          <= in_ch.opcode;
            sat_reg         <= in_sat;
            sat_ok_reg      <= in_sat_ok;
            new_reg.key     <= in_ch.begin_valid;
            new_reg.stop    <= in_ch.end_valid;
            new_reg.epoch   <= in_ch.toe_time;
            new_reg.tag     <= in_ch.entry_tag;
            new_reg.healthy <= in_ch.entry_healthy;
            query_reg       <= in_ch.query_time;
            n_reg           <= in_sat_ok ? fill_reg[in_sat] : '0;
        end
        if (cmd.scan_adv)
        begin
            prev_reg <= rdata_reg;
        end
        if (cmd.add_start)
        begin
            p_reg <= cmd.p_from_n ? n_reg : idx_reg;
        end
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_status;
            if (!cmd.res_found)
            begin
                res_entry_reg <= '0;
            end
            else if (cmd.res_from_cur)
            begin
                res_entry_reg <= rdata_reg;
            end
            else
            begin
                res_entry_reg <= prev_reg;
            end
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_entry_reg  <= res_entry_reg;
        end
    end

    assign out_status = out_status_reg;
    assign out_entry  = out_entry_reg;

    always_comb
    begin
        stat.sat_ok        = sat_ok_reg;
        stat.is_lookup     = (op_reg == OP_LOOKUP);
        stat.n_zero        = (n_reg == '0);
        stat.n_full        = (n_reg >= FILL_BITS'(ENTRIES_PER_SAT));
        stat.last          = (FILL_BITS'(idx_reg + 1'b1) == n_reg);
        stat.idx_zero      = (idx_reg == '0);
        stat.idx_at_p      = (idx_reg == p_reg);
        stat.key_ge        = (rdata_reg.key >= cmp_val);
        stat.key_eq        = (rdata_reg.key == new_reg.key);
        stat.cur_ep_eq     = (rdata_reg.epoch == new_reg.epoch);
        stat.prev_ep_eq    = (prev_reg.epoch == new_reg.epoch);
        stat.cur_in_range  = (rdata_reg.key <= query_reg) && (query_reg <= rdata_reg.stop);
        stat.prev_in_range = (prev_reg.key <= query_reg) && (query_reg <= prev_reg.stop);
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_inc |-> n_reg < FILL_BITS'(ENTRIES_PER_SAT))
        else $error("fill count overflow");
    a_shift_above_p: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_wr |-> idx_reg > p_reg)
        else $error("shift below insert point");
    a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_adv |-> idx_reg < n_reg)
        else $error("scan past fill count");

endmodule

[hdl/evt_ctrl.sv]
`timescale 1ns / 1ps

module evt_ctrl import evt_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_START    = 3'd1;
    localparam logic [2:0] S_SCAN_RD  = 3'd2;
    localparam logic [2:0] S_SCAN_CHK = 3'd3;
    localparam logic [2:0] S_SH_RD    = 3'd4;
    localparam logic [2:0] S_SH_WR    = 3'd5;
    localparam logic [2:0] S_RESULT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (!stat.sat_ok)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = stat.is_lookup ? ST_NONE : ST_FULL;
                    state_next     = S_RESULT;
                end
                else if (stat.n_zero && stat.is_lookup)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_NONE;
                    state_next     = S_RESULT;
                end
                else if (stat.n_zero)
                begin
                    cmd.add_start = 1'b1;
                    cmd.p_from_n  = 1'b1;
                    state_next    = S_SH_RD;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                state_next = S_RESULT;
                if (stat.key_ge)
                begin
                    if (stat.is_lookup)
                    begin
                        cmd.res_set = 1'b1;
                        if (stat.idx_zero)
                        begin
                            cmd.res_status = ST_TOO_LATE;
                        end
                        else if (stat.prev_in_range)
                        begin
                            cmd.res_status = ST_FOUND;
                            cmd.res_found  = 1'b1;
                        end
                        else
                        begin
                            cmd.res_status = ST_GAP;
                        end
                    end
                    else if (stat.key_eq)
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = stat.cur_ep_eq ? ST_DUPLICATE : ST_CONFLICT;
                    end
                    else if (stat.cur_ep_eq)
                    begin
                        cmd.wr_new     = 1'b1;
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_REPLACED;
                    end
                    else if (!stat.idx_zero && stat.prev_ep_eq)
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_DUPLICATE;
                    end
                    else if (stat.n_full)
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_FULL;
                    end
                    else
                    begin
                        cmd.add_start = 1'b1;
                        state_next    = S_SH_RD;
                    end
                end
                else if (stat.last)
                begin
                    if (stat.is_lookup)
                    begin
                        cmd.res_set      = 1'b1;
                        cmd.res_found    = stat.cur_in_range;
                        cmd.res_from_cur = 1'b1;
                        cmd.res_status   = stat.cur_in_range ? ST_FOUND : ST_TOO_EARLY;
                    end
                    else if (stat.cur_ep_eq)
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_DUPLICATE;
                    end
                    else if (stat.n_full)
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_FULL;
                    end
                    else
                    begin
                        cmd.add_start = 1'b1;
                        cmd.p_from_n  = 1'b1;
                        state_next    = S_SH_RD;
                    end
                end
                else
                begin
                    cmd.scan_adv = 1'b1;
                    state_next   = S_SCAN_RD;
                end
            end
            S_SH_RD:
            begin
                if (stat.idx_at_p)
                begin
                    cmd.wr_new     = 1'b1;
                    cmd.fill_inc   = 1'b1;
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_ADDED;
                    state_next     = S_RESULT;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SH_RD;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_shift_pair: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SH_WR |=> state_reg == S_SH_RD)
        else $error("shift write not followed by read");
    a_res_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_set |=> state_reg == S_RESULT)
        else $error("result staged outside result path");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before transfer");

endmodule

[hdl/ephemeris_validity_table_unit.sv]
`timescale 1ns / 1ps

// per-satellite validity table for broadcast element sets
// in_ch: one item per transfer, opcode selects insert or lookup for sat_id
// out_ch: exactly one result transfer per input transfer, in order
// an item is taken only when the unit is idle; one item is in work at a time
// a scan of the selected table reads each entry visited and then checks it
//   (one read port on the entry memory, registered read data)
// an insert that adds an entry then moves the entries above it up,
//   reading and writing each moved entry, then writes the new one
// the finished result sits in an output register; the next item is taken
//   while it waits, and a stalled receiver holds the unit only when a second
//   result is ready before the first transfer
// reset empties all tables (fill counts to zero) and clears valid on out_ch;
//   entry memory is not cleared and needs no sweep
module ephemeris_validity_table_unit import evt_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    evt_in_if.sink    in_ch,
    evt_out_if.source out_ch
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    entry_t   out_entry;
    logic [STATUS_BITS-1:0] out_status;

    evt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    evt_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_status (out_status),
        .out_entry  (out_entry),
        .cmd        (cmd),
        .stat       (stat)
    );

    assign out_ch.status        = out_status;
    assign out_ch.found_tag     = out_entry.tag;
    assign out_ch.found_begin   = out_entry.key;
    assign out_ch.found_end     = out_entry.stop;
    assign out_ch.found_toe     = out_entry.epoch;
    assign out_ch.found_healthy = out_entry.healthy;

endmodule

[tb/sv/evt_tb_if.sv]
`timescale 1ns / 1ps

// the channel interfaces come with the RTL (evt_in_if, evt_out_if); this file
// holds the request type used by stimulus and checker, and the response type
package evt_tb_pkg;
    import evt_pkg::*;

    typedef struct packed {
        logic                 opcode;
        logic [SAT_BITS-1:0]  sat_id;
        logic [TIME_BITS-1:0] begin_valid;
        logic [TIME_BITS-1:0] end_valid;
        logic [TIME_BITS-1:0] toe_time;
        logic [TAG_BITS-1:0]  entry_tag;
        logic                 entry_healthy;
        logic [TIME_BITS-1:0] query_time;
    } table_req_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [TAG_BITS-1:0]    found_tag;
        logic [TIME_BITS-1:0]   found_begin;
        logic [TIME_BITS-1:0]   found_end;
        logic [TIME_BITS-1:0]   found_toe;
        logic                   found_healthy;
    } table_resp_t;
endpackage

[tb/sv/evt_checker.sv]
`timescale 1ns / 1ps

module evt_checker import evt_pkg::*; import evt_tb_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    evt_in_if.sink    in_mon,
    evt_out_if.sink   out_mon,
    output int        fail_count,
    output int        pending
);
    entry_t           sat_table [NUM_SATS][ENTRIES_PER_SAT];
    int               sat_fill [NUM_SATS];
    table_resp_t      expected_resp [$];

    function automatic void put_entry(int s, int i, table_req_t r);
        sat_table[s][i].key     = r.begin_valid;
        sat_table[s][i].stop    = r.end_valid;
        sat_table[s][i].epoch   = r.toe_time;
        sat_table[s][i].tag     = r.entry_tag;
        sat_table[s][i].healthy = r.entry_healthy;
    endfunction

    function automatic logic [STATUS_BITS-1:0] add_entry(int s, int p, table_req_t r);
        int n;
        n = sat_fill[s];
        if (n >= ENTRIES_PER_SAT)
            return ST_FULL;
        for (int i = n; i > p; i--)
            sat_table[s][i] = sat_table[s][i-1];
        put_entry(s, p, r);
        sat_fill[s] = n + 1;
        return ST_ADDED;
    endfunction

    function automatic table_resp_t predict_table(table_req_t r);
        table_resp_t res;
        int s, n, p;
        res = '0;
        s = int'(r.sat_id);
        if (s >= NUM_SATS)
        begin
            res.status = (r.opcode == OP_LOOKUP) ? ST_NONE : ST_FULL;
            return res;
        end
        n = sat_fill[s];
        p = 0;
        if (r.opcode == OP_INSERT)
        begin
            if (n == 0)
                res.status = add_entry(s, 0, r);
            else
            begin
                while (p < n && sat_table[s][p].key < r.begin_valid)
                    p++;
                if (p < n && sat_table[s][p].key == r.begin_valid)
                    res.status = (sat_table[s][p].epoch == r.toe_time) ? ST_DUPLICATE
                                                                       : ST_CONFLICT;
                else if (p == n)
                    res.status = (sat_table[s][n-1].epoch == r.toe_time) ? ST_DUPLICATE
                                                                         : add_entry(s, n, r);
                else if (sat_table[s][p].epoch == r.toe_time)
                begin
                    put_entry(s, p, r);
                    res.status = ST_REPLACED;
                end
                else if (p > 0 && sat_table[s][p-1].epoch == r.toe_time)
                    res.status = ST_DUPLICATE;
                else
                    res.status = add_entry(s, p, r);
            end
        end
        else if (n == 0)
            res.status = ST_NONE;
        else
        begin
            while (p < n && sat_table[s][p].key < r.query_time)
                p++;
            if (p == 0)
                res.status = ST_TOO_LATE;
            else if (sat_table[s][p-1].key <= r.query_time
                     && r.query_time <= sat_table[s][p-1].stop)
            begin
                res.status        = ST_FOUND;
                res.found_tag     = sat_table[s][p-1].tag;
                res.found_begin   = sat_table[s][p-1].key;
                res.found_end     = sat_table[s][p-1].stop;
                res.found_toe     = sat_table[s][p-1].epoch;
                res.found_healthy = sat_table[s][p-1].healthy;
            end
            else
                res.status = (p == n) ? ST_TOO_EARLY : ST_GAP;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_req_t  req;
        table_resp_t got, exp_r;
        if (!rst_n)
        begin
            fail_count <= 0;
            expected_resp.delete();
            pending = 0;
            for (int s = 0; s < NUM_SATS; s++)
                sat_fill[s] = 0;
        end
        else
        begin
            if (in_mon.valid && in_mon.ready)
            begin
                req = '{in_mon.opcode, in_mon.sat_id, in_mon.begin_valid, in_mon.end_valid,
                        in_mon.toe_time, in_mon.entry_tag, in_mon.entry_healthy,
                        in_mon.query_time};
                expected_resp.insert(expected_resp.size(), predict_table(req));
            end
            if (out_mon.valid && out_mon.ready)
            begin
                got = '{out_mon.status, out_mon.found_tag, out_mon.found_begin,
                        out_mon.found_end, out_mon.found_toe, out_mon.found_healthy};
                if (expected_resp.size() == 0)
                begin
                    $display("%0t unexpected transfer: got %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_resp.pop_front();
                    if (got !== exp_r)
                    begin
                        $display("%0t status exp %0d got %0d", $time, exp_r.status,
                                 got.status);
                        $display("%0t tag exp %h got %h begin exp %h got %h", $time,
                                 exp_r.found_tag, got.found_tag, exp_r.found_begin,
                                 got.found_begin);
                        $display("%0t end exp %h got %h toe exp %h got %h hlth %b/%b",
                                 $time, exp_r.found_end, got.found_end, exp_r.found_toe,
                                 got.found_toe, exp_r.found_healthy, got.found_healthy);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending = expected_resp.size();
        end
    end
endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import evt_pkg::*;
    import evt_tb_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   stall_mode;
    logic [TIME_BITS-1:0] epoch_pool [8];

    evt_in_if  in_ch();
    evt_out_if out_ch();

    ephemeris_validity_table_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    evt_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    initial
    begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [TIME_BITS-1:0] rand_time();
        return TIME_BITS'({$urandom(), $urandom()});
    endfunction

    // small time values so keys, queries and epochs collide often
    function automatic logic [TIME_BITS-1:0] near_time();
        return TIME_BITS'($urandom_range(0, 60));
    endfunction

    task automatic send(table_req_t r);
        in_ch.valid         <= 1'b1;
        in_ch.opcode        <= r.opcode;
        in_ch.sat_id        <= r.sat_id;
        in_ch.begin_valid   <= r.begin_valid;
        in_ch.end_valid     <= r.end_valid;
        in_ch.toe_time      <= r.toe_time;
        in_ch.entry_tag     <= r.entry_tag;
        in_ch.entry_healthy <= r.entry_healthy;
        in_ch.query_time    <= r.query_time;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic gap(int n);
        if (n > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic ins(int s, logic [TIME_BITS-1:0] b, logic [TIME_BITS-1:0] e,
                       logic [TIME_BITS-1:0] t);
        table_req_t r;
        r = '{OP_INSERT, s[SAT_BITS-1:0], b, e, t, $urandom(), 1'($urandom()), rand_time()};
        send(r);
    endtask

    task automatic look(int s, logic [TIME_BITS-1:0] q);
        table_req_t r;
        r = '{OP_LOOKUP, s[SAT_BITS-1:0], rand_time(), rand_time(), rand_time(), $urandom(),
              1'($urandom()), q};
        send(r);
    endtask

    // receiver: random stall per item, a long hold-off in mode 1
    always @(posedge clk or negedge rst_n)
    begin
        int wait_left;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            wait_left = 0;
        end
        else if (stall_mode == 1)
            out_ch.ready <= 1'b0;
        else if (stall_mode == 2)
            out_ch.ready <= 1'b1;
        else if (out_ch.valid && out_ch.ready)
        begin
            wait_left = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
            out_ch.ready <= (wait_left == 0);
        end
        else if (wait_left > 0)
        begin
            wait_left--;
            out_ch.ready <= (wait_left == 0);
        end
        else
            out_ch.ready <= 1'b1;
    end

    initial
    begin
        int s, k;
        logic [TIME_BITS-1:0] b;
        logic [TIME_BITS-1:0] all1;
        all1 = '1;
        stall_mode = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_INSERT;
        in_ch.sat_id = '0;
        in_ch.begin_valid = '0;
        in_ch.end_valid = '0;
        in_ch.toe_time = '0;
        in_ch.entry_tag = '0;
        in_ch.entry_healthy = 1'b0;
        in_ch.query_time = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, add, duplicate, conflict, replace, lookups
        look(3, 100);
        ins(3, 100, 199, 90);
        ins(3, 100, 150, 90);
        ins(3, 100, 150, 91);
        ins(3, 300, 399, 290);
        ins(3, 350, 360, 290);
        ins(3, 50, 60, 90);
        ins(3, 200, 250, 95);
        ins(3, 250, 260, 290);
        look(3, 40);
        look(3, 50);
        look(3, 60);
        look(3, 61);
        look(3, 300);
        look(3, 399);
        look(3, 400);
        ins(31, 0, all1, all1);
        look(31, all1);
        look(31, 0);
        ins(0, all1, all1, 0);
        look(0, all1);
        // fill sat 7 to the limit, then overflow
        for (int i = 0; i <= ENTRIES_PER_SAT; i++)
            ins(7, TIME_BITS'(1000 - 10 * i), TIME_BITS'(1005 - 10 * i), TIME_BITS'(i));
        gap(1);

        for (int i = 0; i < 8; i++)
            epoch_pool[i] = $urandom_range(0, 1) ? near_time() : rand_time();
        for (int n = 0; n < 550; n++)
        begin
            if (n == 200)
            begin
                stall_mode = 1;
                fork
                    begin
                        repeat (300) @(posedge clk);
                        stall_mode = 0;
                    end
                join_none
            end
            if (n == 350)
            begin
                stall_mode = 2;
                gap(1);
                wait (pending == 0);
                stall_mode = 0;
            end
            s = $urandom_range(0, 7);
            k = $urandom_range(0, 9);
            if (k < 5)
            begin
                b = (k == 0) ? rand_time() : near_time();
                ins(s, b, b + TIME_BITS'($urandom_range(0, 12)),
                    epoch_pool[$urandom_range(0, 7)]);
            end
            else
                look(s, (k == 9) ? rand_time()
                                 : near_time() + TIME_BITS'($urandom_range(0, 12)));
            if (n > 400 || $urandom_range(0, 1) == 0)
                gap($urandom_range(0, 17));
        end
        in_ch.valid <= 1'b0;
        stall_mode = 0;
        wait (pending == 0);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
